[src/source_tokenizer_top_macros.svh]
// Assertion macros for the source tokenizer.
// Used inside modules that have i_clk and the active-low reset i_rst_n.
`ifndef SOURCE_TOKENIZER_TOP_MACROS_SVH
`define SOURCE_TOKENIZER_TOP_MACROS_SVH

// Check a consequence in the same cycle as its condition.
`define ST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its condition.
`define ST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/stok_pkg.sv]
// Package for the source tokenizer: scan modes, token kinds, token record,
// character constants, word table and operator lookup functions.
// No dependencies.
package stok_pkg;

    // Default parameter values
    localparam int DEF_POSITION_BITS = 16;
    localparam int DEF_LENGTH_BITS   = 8;

    // Token queue depth (power of two)
    localparam int FIFO_DEPTH = 4;

    // Scan modes
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_NUMBER  = 3'd2,
        MODE_OPER    = 3'd3,
        MODE_COMMENT = 3'd4
    } t_mode;

    // Token kinds
    typedef enum logic [4:0] {
        KIND_IDENT    = 5'd0,
        KIND_KEYWORD  = 5'd1,
        KIND_TYPE     = 5'd2,
        KIND_NUMBER   = 5'd3,
        KIND_LPAREN   = 5'd4,
        KIND_RPAREN   = 5'd5,
        KIND_LBRACE   = 5'd6,
        KIND_RBRACE   = 5'd7,
        KIND_SEMI     = 5'd8,
        KIND_COLON    = 5'd9,
        KIND_COMMA    = 5'd10,
        KIND_PLUS     = 5'd11,
        KIND_MINUS    = 5'd12,
        KIND_ARROW    = 5'd13,
        KIND_STAR     = 5'd14,
        KIND_SLASH    = 5'd15,
        KIND_NOT_EQ   = 5'd16,
        KIND_ASSIGN   = 5'd17,
        KIND_EQ       = 5'd18,
        KIND_LESS     = 5'd19,
        KIND_LESS_EQ  = 5'd20,
        KIND_GREATER  = 5'd21,
        KIND_GREAT_EQ = 5'd22,
        KIND_AND      = 5'd23,
        KIND_OR       = 5'd24,
        KIND_END      = 5'd25
    } t_kind;

    // One token as it leaves the block
    typedef struct packed {
        t_kind       kind;
        logic [3:0]  word_index;
        logic [15:0] line;
        logic [15:0] column;
        logic [7:0]  length;
        logic        last;
    } t_token;

    // Characters
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // Keyword and type-name table; entries from TYPE_FIRST on are type names
    localparam int NUM_WORDS  = 9;
    localparam int TYPE_FIRST = 7;
    localparam int PREFIX_CHARS = 6;

    localparam logic [47:0] WORD_TEXT [NUM_WORDS] = '{
        48'h72_65_74_75_72_6E, // return
        48'h00_00_66_75_6E_63, // func
        48'h00_00_00_00_69_66, // if
        48'h00_00_65_6C_73_65, // else
        48'h00_00_00_66_6F_72, // for
        48'h00_77_68_69_6C_65, // while
        48'h00_00_00_00_69_6E, // in
        48'h00_00_00_69_6E_74, // int
        48'h00_61_72_72_61_79  // array
    };

    localparam logic [2:0] WORD_LEN [NUM_WORDS] = '{
        3'd6, 3'd4, 3'd2, 3'd4, 3'd3, 3'd5, 3'd2, 3'd3, 3'd5
    };

    // Single-character token kind; KIND_IDENT means no such token
    function automatic t_kind f_single_kind(input logic [7:0] c);
        t_kind k;
        unique case (c)
            CH_LPAREN:  k = KIND_LPAREN;
            CH_RPAREN:  k = KIND_RPAREN;
            CH_LBRACE:  k = KIND_LBRACE;
            CH_RBRACE:  k = KIND_RBRACE;
            CH_SEMI:    k = KIND_SEMI;
            CH_COLON:   k = KIND_COLON;
            CH_COMMA:   k = KIND_COMMA;
            CH_PLUS:    k = KIND_PLUS;
            CH_MINUS:   k = KIND_MINUS;
            CH_STAR:    k = KIND_STAR;
            CH_SLASH:   k = KIND_SLASH;
            CH_EQUAL:   k = KIND_ASSIGN;
            CH_LESS:    k = KIND_LESS;
            CH_GREATER: k = KIND_GREATER;
            default:    k = KIND_IDENT;
        endcase
        return k;
    endfunction

    // Two-character operator kind; KIND_IDENT means no such operator
    function automatic t_kind f_pair_kind(input logic [7:0] a, input logic [7:0] b);
        t_kind k;
        k = KIND_IDENT;
        if (a == CH_MINUS && b == CH_GREATER) k = KIND_ARROW;
        if (a == CH_BANG && b == CH_EQUAL) k = KIND_NOT_EQ;
        if (a == CH_EQUAL && b == CH_EQUAL) k = KIND_EQ;
        if (a == CH_LESS && b == CH_EQUAL) k = KIND_LESS_EQ;
        if (a == CH_GREATER && b == CH_EQUAL) k = KIND_GREAT_EQ;
        if (a == CH_AMP && b == CH_AMP) k = KIND_AND;
        if (a == CH_PIPE && b == CH_PIPE) k = KIND_OR;
        return k;
    endfunction

    // Characters that may open a two-character operator or a comment
    function automatic logic f_starts_pair(input logic [7:0] c);
        return c == CH_MINUS || c == CH_BANG || c == CH_EQUAL || c == CH_LESS ||
               c == CH_GREATER || c == CH_AMP || c == CH_PIPE || c == CH_SLASH;
    endfunction

    function automatic logic f_is_alpha(input logic [7:0] c);
        logic [7:0] l;
        l = c | CASE_BIT;
        return l >= CH_LOW_A && l <= CH_LOW_Z;
    endfunction

    function automatic logic f_is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic f_is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

[src/source_tokenizer_top.sv]
// Source tokenizer top level: input register, scanner logic, token queue.
// Depends on stok_pkg and source_tokenizer_top_macros.svh.

// The tokenizer takes one source byte per input transaction (byte 0 ends the
// text and returns the block to its start positions) and delivers one token
// per output transaction. A byte is taken into an input register, scanned
// from there once the queue has room, and its tokens go into the token queue.
// Input is accepted every cycle while the four-entry token queue has two free
// entries. A byte that both ends a word or operator and forms a token of its
// own yields two tokens, and the queue delivers one token per output
// transaction, so such bytes lower the sustained rate below one byte per cycle.
module source_tokenizer_top #(
    parameter int POSITION_BITS = stok_pkg::DEF_POSITION_BITS,
    parameter int LENGTH_BITS   = stok_pkg::DEF_LENGTH_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // source byte channel
    input  logic        i_src_valid,
    output logic        o_src_stall,
    input  logic [7:0]  i_source_byte,
    // token channel
    output logic        o_tok_valid,
    input  logic        i_tok_stall,
    output logic [4:0]  o_token_kind,
    output logic [3:0]  o_word_index,
    output logic [15:0] o_start_line,
    output logic [15:0] o_start_column,
    output logic [7:0]  o_token_length,
    output logic        o_last_of_run
);
    import stok_pkg::*;

    // Counters never exceed the 16-bit and 8-bit output fields
    localparam int PW = (POSITION_BITS < 16) ? POSITION_BITS : 16;
    localparam int LW = (LENGTH_BITS < 8) ? LENGTH_BITS : 8;
    localparam int PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS = PTR_BITS + 1;

    function automatic logic [PW-1:0] f_pos_inc(input logic [PW-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Scanner state
    t_mode          r_mode, n_mode;
    logic [7:0]     r_pend, n_pend;
    logic [PW-1:0]  r_line, n_line;
    logic [PW-1:0]  r_col, n_col;
    logic [PW-1:0]  r_sline, n_sline;
    logic [PW-1:0]  r_scol, n_scol;
    logic [LW-1:0]  r_count, n_count;
    logic [47:0]    r_prefix, n_prefix;

    // Token queue
    t_token                r_fifo [FIFO_DEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0]   r_fcount;

    logic       w_process;
    logic       w_pop;
    logic       w_done;
    logic       w_tok0_v, w_tok1_v;
    t_token     w_tok0, w_tok1;
    t_token     w_first;
    logic [1:0] w_push_cnt;
    logic [PW-1:0] w_col1;
    logic       w_word_hit;
    logic [3:0] w_word_idx;
    t_kind      w_pair, w_single;

    // Scan only when the queue can take both tokens of a byte
    assign w_process   = r_in_valid && (r_fcount <= CNT_BITS'(FIFO_DEPTH - 2));
    assign o_src_stall = r_in_valid && !w_process;
    assign w_pop       = o_tok_valid && !i_tok_stall;

    // Hold the byte until it is scanned
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_src_valid && !o_src_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_process) begin
            r_in_valid <= 1'b0;
        end
        if (i_src_valid && !o_src_stall) begin
            r_in_byte <= i_source_byte;
        end
    end

    // Match the finished word against the keyword table
    always_comb begin
        w_word_hit = 1'b0;
        w_word_idx = '0;
        for (int i = NUM_WORDS - 1; i >= 0; i--) begin
            if (r_count == LW'(WORD_LEN[i]) && r_prefix == WORD_TEXT[i]) begin
                w_word_hit = 1'b1;
                w_word_idx = 4'(i);
            end
        end
    end

    assign w_pair   = f_pair_kind(r_pend, r_in_byte);
    assign w_single = f_single_kind(r_pend);
    assign w_col1   = (r_in_byte != CH_NUL) ? f_pos_inc(r_col) : r_col;

    // Scan one byte: close the pending token, then handle the byte itself
    always_comb begin
        n_mode   = r_mode;
        n_pend   = r_pend;
        n_line   = r_line;
        n_col    = w_col1;
        n_sline  = r_sline;
        n_scol   = r_scol;
        n_count  = r_count;
        n_prefix = r_prefix;
        w_done   = 1'b0;
        w_tok0_v = 1'b0;
        w_tok1_v = 1'b0;
        w_tok0   = '0;
        w_tok1   = '0;

        unique case (r_mode)
            MODE_IDENT, MODE_NUMBER: begin
                if (f_is_alpha(r_in_byte) || f_is_digit(r_in_byte) ||
                    (r_in_byte == CH_UNDER && r_mode == MODE_IDENT)) begin
                    // extend the word
                    if (r_count < LW'(PREFIX_CHARS + 1)) begin
                        n_prefix = {r_prefix[39:0], r_in_byte};
                    end
                    if (!(&r_count)) begin
                        n_count = r_count + 1'b1;
                    end
                    w_done = 1'b1;
                end else begin
                    // emit the finished word
                    w_tok0_v        = 1'b1;
                    w_tok0.kind     = (r_mode == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
                    if (r_mode == MODE_IDENT && w_word_hit) begin
                        w_tok0.kind       = (w_word_idx < 4'(TYPE_FIRST)) ?
                                            KIND_KEYWORD : KIND_TYPE;
                        w_tok0.word_index = w_word_idx;
                    end
                    w_tok0.line   = 16'(r_sline);
                    w_tok0.column = 16'(r_scol);
                    w_tok0.length = 8'(r_count);
                    n_mode        = MODE_IDLE;
                end
            end
            MODE_OPER: begin
                if (w_pair != KIND_IDENT) begin
                    w_tok0_v      = 1'b1;
                    w_tok0.kind   = w_pair;
                    w_tok0.line   = 16'(r_sline);
                    w_tok0.column = 16'(r_scol);
                    w_tok0.length = 8'd2;
                    n_mode        = MODE_IDLE;
                    w_done        = 1'b1;
                end else if (r_pend == CH_SLASH && r_in_byte == CH_SLASH) begin
                    n_mode = MODE_COMMENT;
                    w_done = 1'b1;
                end else begin
                    // a lone bang, ampersand or pipe is dropped
                    if (w_single != KIND_IDENT) begin
                        w_tok0_v      = 1'b1;
                        w_tok0.kind   = w_single;
                        w_tok0.line   = 16'(r_sline);
                        w_tok0.column = 16'(r_scol);
                        w_tok0.length = 8'd1;
                    end
                    n_mode = MODE_IDLE;
                end
                if (n_mode == MODE_IDLE) begin
                    n_pend = '0;
                end
            end
            MODE_COMMENT: begin
                if (r_in_byte == CH_NL) begin
                    n_line = f_pos_inc(r_line);
                    n_col  = '0;
                    n_mode = MODE_IDLE;
                    w_done = 1'b1;
                end else if (r_in_byte != CH_NUL) begin
                    w_done = 1'b1;
                end else begin
                    n_mode = MODE_IDLE;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase

        if (!w_done) begin
            priority if (r_in_byte == CH_NUL) begin
                // end token, then back to start positions
                w_tok1_v      = 1'b1;
                w_tok1.kind   = KIND_END;
                w_tok1.line   = 16'(r_line);
                w_tok1.column = 16'(f_pos_inc(r_col));
                w_tok1.length = 8'd1;
                n_mode   = MODE_IDLE;
                n_pend   = '0;
                n_line   = PW'(1);
                n_col    = '0;
                n_sline  = PW'(1);
                n_scol   = '0;
                n_count  = '0;
                n_prefix = '0;
            end else if (r_in_byte == CH_NL) begin
                n_line = f_pos_inc(r_line);
                n_col  = '0;
            end else if (f_is_space(r_in_byte)) begin
                n_mode = n_mode;
            end else if (f_is_alpha(r_in_byte) || r_in_byte == CH_UNDER ||
                         f_is_digit(r_in_byte) || f_starts_pair(r_in_byte)) begin
                // open a word, number or operator
                n_mode   = f_is_digit(r_in_byte) ? MODE_NUMBER :
                           f_starts_pair(r_in_byte) ? MODE_OPER : MODE_IDENT;
                n_sline  = r_line;
                n_scol   = w_col1;
                n_count  = LW'(1);
                n_prefix = {40'd0, r_in_byte};
                n_pend   = f_starts_pair(r_in_byte) ? r_in_byte : 8'd0;
            end else if (f_single_kind(r_in_byte) != KIND_IDENT) begin
                w_tok1_v      = 1'b1;
                w_tok1.kind   = f_single_kind(r_in_byte);
                w_tok1.line   = 16'(r_line);
                w_tok1.column = 16'(w_col1);
                w_tok1.length = 8'd1;
            end else begin
                // unknown byte: skip
                n_mode = n_mode;
            end
        end

        w_tok1.last = 1'b1;
    end

    // Order the tokens of this byte; the last one carries the run mark
    always_comb begin
        w_first      = w_tok0_v ? w_tok0 : w_tok1;
        w_first.last = !(w_tok0_v && w_tok1_v);
        w_push_cnt   = w_process ? (2'(w_tok0_v) + 2'(w_tok1_v)) : 2'd0;
    end

    // Advance scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_pend   <= '0;
            r_line   <= PW'(1);
            r_col    <= '0;
            r_sline  <= PW'(1);
            r_scol   <= '0;
            r_count  <= '0;
            r_prefix <= '0;
        end else if (w_process) begin
            r_mode   <= n_mode;
            r_pend   <= n_pend;
            r_line   <= n_line;
            r_col    <= n_col;
            r_sline  <= n_sline;
            r_scol   <= n_scol;
            r_count  <= n_count;
            r_prefix <= n_prefix;
        end
    end

    // Token queue: push up to two, pop one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fcount <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_BITS'(w_push_cnt);
            r_rd_ptr <= r_rd_ptr + PTR_BITS'(w_pop);
            r_fcount <= r_fcount + CNT_BITS'(w_push_cnt) - CNT_BITS'(w_pop);
        end
        if (w_push_cnt != 2'd0) begin
            r_fifo[r_wr_ptr] <= w_first;
        end
        if (w_push_cnt == 2'd2) begin
            r_fifo[PTR_BITS'(r_wr_ptr + 1'b1)] <= w_tok1;
        end
    end

    // Drive the token channel from the queue head
    assign o_tok_valid    = (r_fcount != '0);
    assign o_token_kind   = r_fifo[r_rd_ptr].kind;
    assign o_word_index   = r_fifo[r_rd_ptr].word_index;
    assign o_start_line   = r_fifo[r_rd_ptr].line;
    assign o_start_column = r_fifo[r_rd_ptr].column;
    assign o_token_length = r_fifo[r_rd_ptr].length;
    assign o_last_of_run  = r_fifo[r_rd_ptr].last;

    `include "source_tokenizer_top_macros.svh"

    // Queue never holds more than its depth
    `ST_ASSERT_NOW(a_fifo_bound, 1'b1, r_fcount <= CNT_BITS'(FIFO_DEPTH), "token queue overflow")
    // Fill count follows pushes and pops
    `ST_ASSERT_NEXT(a_fifo_count, 1'b1, r_fcount == CNT_BITS'($past(r_fcount) + CNT_BITS'($past(w_push_cnt)) - CNT_BITS'($past(w_pop))), "token queue count mismatch")
    // Two tokens from one byte: only the second closes the run
    `ST_ASSERT_NOW(a_run_mark, w_push_cnt == 2'd2, !w_first.last && w_tok1.last, "run mark misplaced")
    // End of text returns the scanner to its start positions
    `ST_ASSERT_NEXT(a_end_reset, w_process && r_in_byte == CH_NUL, r_line == PW'(1) && r_col == '0 && r_mode == MODE_IDLE, "scanner not reset after end of text")
    // Every delivered token starts at line and column one or later
    `ST_ASSERT_NOW(a_start_pos, o_tok_valid, o_start_line != 16'd0 && o_start_column != 16'd0, "token start position zero")

endmodule

[sim/source_tokenizer_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for source_tokenizer_top: drives source text one byte per
// transaction and checks every token against an in-bench scanner model or a typed directed-table row.
// Depends on stok_pkg and the source_tokenizer_top RTL.
module source_tokenizer_top_tb;
    import stok_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_BYTES = 200;
    localparam int LONG_WORD    = 260;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE       = 10;
    localparam int LIMIT_NS     = 8_000_000;
    localparam int POS_LIMIT    = 2 ** DEF_POSITION_BITS - 1;
    localparam int LEN_LIMIT    = 2 ** DEF_LENGTH_BITS - 1;
    localparam int NUM_OPS      = 24;

    // Random text is built from these pieces
    typedef enum int {
        FRAG_KEYWORD, FRAG_IDENT, FRAG_NUMBER, FRAG_OPERATOR,
        FRAG_COMMENT, FRAG_BLANK, FRAG_NOISE, FRAG_END
    } t_frag;

    // Patterns of back pressure on the token side
    typedef enum int {
        STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE
    } t_stall_style;

    // One row of the directed table; typed rows carry their single token
    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        t_token     tok;
    } t_row;

    localparam int NUM_ROWS = 24;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_src_valid = 1'b0;
    logic        o_src_stall;
    logic [7:0]  i_source_byte = 8'h00;
    logic        o_tok_valid;
    logic        i_tok_stall = 1'b0;
    logic [4:0]  o_token_kind;
    logic [3:0]  o_word_index;
    logic [15:0] o_start_line;
    logic [15:0] o_start_column;
    logic [7:0]  o_token_length;
    logic        o_last_of_run;

    source_tokenizer_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_src_valid    (i_src_valid),
        .o_src_stall    (o_src_stall),
        .i_source_byte  (i_source_byte),
        .o_tok_valid    (o_tok_valid),
        .i_tok_stall    (i_tok_stall),
        .o_token_kind   (o_token_kind),
        .o_word_index   (o_word_index),
        .o_start_line   (o_start_line),
        .o_start_column (o_start_column),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    string kw_text [NUM_WORDS] = '{
        "return", "func", "if", "else", "for", "while", "in", "int", "array"
    };

    string op_text [NUM_OPS] = '{
        "(", ")", "{", "}", ";", ":", ",", "+", "-", "->", "*", "/",
        "!=", "=", "==", "<", "<=", ">", ">=", "&&", "||", "!", "&", "|"
    };

    // Directed text: reset tokens, stray bytes, lone operators, back-to-back
    // comments, a type name and a number each closed by a token of its own
    t_row dir_rows [NUM_ROWS] = '{
        '{CH_LPAREN, 1'b1, '{KIND_LPAREN, 4'd0, 16'd1, 16'd1, 8'd1, 1'b1}},
        '{CH_NUL,    1'b1, '{KIND_END,    4'd0, 16'd1, 16'd2, 8'd1, 1'b1}},
        '{8'hFF,     1'b0, '0},
        '{CH_BANG,   1'b0, '0},
        '{"x",       1'b0, '0},
        '{CH_EQUAL,  1'b0, '0},
        '{CH_EQUAL,  1'b0, '0},
        '{CH_SLASH,  1'b0, '0},
        '{CH_SLASH,  1'b0, '0},
        '{CH_SLASH,  1'b0, '0},
        '{CH_NL,     1'b0, '0},
        '{CH_SLASH,  1'b0, '0},
        '{CH_SLASH,  1'b0, '0},
        '{8'h80,     1'b0, '0},
        '{CH_NL,     1'b0, '0},
        '{CH_AMP,    1'b0, '0},
        '{CH_PIPE,   1'b0, '0},
        '{CH_PIPE,   1'b0, '0},
        '{"i",       1'b0, '0},
        '{"n",       1'b0, '0},
        '{"t",       1'b0, '0},
        '{CH_RPAREN, 1'b0, '0},
        '{"7",       1'b0, '0},
        '{CH_NUL,    1'b0, '0}
    };

    // Scanner model state
    t_mode       scan_st;
    logic [7:0]  op_held;
    int unsigned line_now, col_now, tok_line, tok_col, tok_chars;
    logic [47:0] word_head;

    t_token     step_tokens [$];
    t_token     tokens_due [$];
    logic [7:0] frag [$];

    int n_errors = 0;
    int n_checked = 0;
    int n_sent = 0;
    int burst_left = 0;
    bit src_bursty = 1'b1;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;
    int stall_span = 0;
    t_stall_style stall_style = STALL_NONE;

    function automatic int unsigned bump(input int unsigned v);
        return (v >= POS_LIMIT) ? POS_LIMIT : v + 1;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        logic [7:0] l;
        l = c | CASE_BIT;
        return l >= CH_LOW_A && l <= CH_LOW_Z;
    endfunction

    function automatic bit is_numeral(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit opens_pair(input logic [7:0] c);
        return c == CH_MINUS || c == CH_BANG || c == CH_EQUAL || c == CH_LESS
            || c == CH_GREATER || c == CH_AMP || c == CH_PIPE || c == CH_SLASH;
    endfunction

    // Kind of a one-character token; KIND_IDENT when the byte forms none
    function automatic t_kind lone_kind(input logic [7:0] c);
        case (c)
            CH_LPAREN:  return KIND_LPAREN;
            CH_RPAREN:  return KIND_RPAREN;
            CH_LBRACE:  return KIND_LBRACE;
            CH_RBRACE:  return KIND_RBRACE;
            CH_SEMI:    return KIND_SEMI;
            CH_COLON:   return KIND_COLON;
            CH_COMMA:   return KIND_COMMA;
            CH_PLUS:    return KIND_PLUS;
            CH_MINUS:   return KIND_MINUS;
            CH_STAR:    return KIND_STAR;
            CH_SLASH:   return KIND_SLASH;
            CH_EQUAL:   return KIND_ASSIGN;
            CH_LESS:    return KIND_LESS;
            CH_GREATER: return KIND_GREATER;
            default:    return KIND_IDENT;
        endcase
    endfunction

    // Kind of a two-character operator; KIND_IDENT when the pair forms none
    function automatic t_kind duo_kind(input logic [7:0] a, input logic [7:0] b);
        if (a == CH_MINUS && b == CH_GREATER) return KIND_ARROW;
        if (a == CH_BANG && b == CH_EQUAL) return KIND_NOT_EQ;
        if (a == CH_EQUAL && b == CH_EQUAL) return KIND_EQ;
        if (a == CH_LESS && b == CH_EQUAL) return KIND_LESS_EQ;
        if (a == CH_GREATER && b == CH_EQUAL) return KIND_GREAT_EQ;
        if (a == CH_AMP && b == CH_AMP) return KIND_AND;
        if (a == CH_PIPE && b == CH_PIPE) return KIND_OR;
        return KIND_IDENT;
    endfunction

    function automatic logic [47:0] word_code(input string s);
        logic [47:0] p;
        int k;
        p = '0;
        for (k = 0; k < s.len(); k++) p = {p[39:0], s[k]};
        return p;
    endfunction

    function automatic void clear_scan();
        scan_st   = MODE_IDLE;
        op_held   = 8'h00;
        line_now  = 1;
        col_now   = 0;
        tok_line  = 1;
        tok_col   = 0;
        tok_chars = 0;
        word_head = '0;
    endfunction

    function automatic void add_token(input t_kind kind, input logic [3:0] idx,
                                      input int unsigned ln, input int unsigned cl,
                                      input int unsigned cnt);
        t_token t;
        t.kind       = kind;
        t.word_index = idx;
        t.line       = 16'(ln);
        t.column     = 16'(cl);
        t.length     = (cnt > LEN_LIMIT) ? 8'(LEN_LIMIT) : 8'(cnt);
        t.last       = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void start_token(input t_mode mode, input logic [7:0] b);
        scan_st   = mode;
        tok_line  = line_now;
        tok_col   = col_now;
        tok_chars = 1;
        word_head = {40'd0, b};
        op_held   = (mode == MODE_OPER) ? b : 8'h00;
    endfunction

    // Close the current word, classing identifiers against the word table
    function automatic void close_word();
        t_kind      k;
        logic [3:0] idx;
        bit         found;
        int         i;
        k     = (scan_st == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
        idx   = 4'd0;
        found = 1'b0;
        if (scan_st == MODE_IDENT) begin
            for (i = 0; i < NUM_WORDS; i++) begin
                if (!found && kw_text[i].len() == tok_chars
                    && word_code(kw_text[i]) == word_head) begin
                    found = 1'b1;
                    k     = (i < TYPE_FIRST) ? KIND_KEYWORD : KIND_TYPE;
                    idx   = 4'(i);
                end
            end
        end
        add_token(k, idx, tok_line, tok_col, tok_chars);
    endfunction

    // Advance the scanner model by one byte; tokens land in step_tokens
    function automatic void scan_byte(input logic [7:0] b);
        bit    consumed;
        t_kind k;
        consumed = 1'b0;
        step_tokens.delete();
        if (b != CH_NUL) col_now = bump(col_now);

        case (scan_st)
            MODE_IDENT, MODE_NUMBER: begin
                if (is_letter(b) || is_numeral(b)
                    || (b == CH_UNDER && scan_st == MODE_IDENT)) begin
                    if (tok_chars < 7) word_head = {word_head[39:0], b};
                    if (tok_chars < LEN_LIMIT) tok_chars++;
                    consumed = 1'b1;
                end else begin
                    close_word();
                    scan_st = MODE_IDLE;
                end
            end
            MODE_OPER: begin
                k = duo_kind(op_held, b);
                if (k != KIND_IDENT) begin
                    add_token(k, 4'd0, tok_line, tok_col, 2);
                    scan_st  = MODE_IDLE;
                    consumed = 1'b1;
                end else if (op_held == CH_SLASH && b == CH_SLASH) begin
                    scan_st  = MODE_COMMENT;
                    consumed = 1'b1;
                end else begin
                    // drop a lone ! & | and let this byte be scanned normally
                    k = lone_kind(op_held);
                    if (k != KIND_IDENT) add_token(k, 4'd0, tok_line, tok_col, 1);
                    scan_st = MODE_IDLE;
                end
                if (scan_st == MODE_IDLE) op_held = 8'h00;
            end
            MODE_COMMENT: begin
                if (b == CH_NL) begin
                    line_now = bump(line_now);
                    col_now  = 0;
                    scan_st  = MODE_IDLE;
                    consumed = 1'b1;
                end else if (b != CH_NUL) begin
                    consumed = 1'b1;
                end else begin
                    scan_st = MODE_IDLE;
                end
            end
            default: scan_st = MODE_IDLE;
        endcase

        if (!consumed) begin
            if (b == CH_NUL) begin
                add_token(KIND_END, 4'd0, line_now, bump(col_now), 1);
                clear_scan();
            end else if (b == CH_NL) begin
                line_now = bump(line_now);
                col_now  = 0;
            end else if (is_blank(b)) begin
                // separator only
            end else if (is_letter(b) || b == CH_UNDER) begin
                start_token(MODE_IDENT, b);
            end else if (is_numeral(b)) begin
                start_token(MODE_NUMBER, b);
            end else if (opens_pair(b)) begin
                start_token(MODE_OPER, b);
            end else begin
                k = lone_kind(b);
                if (k != KIND_IDENT) add_token(k, 4'd0, line_now, col_now, 1);
            end
        end
    endfunction

    // Offer one byte, honoring the burst pattern, and queue its tokens
    task automatic send_char(input logic [7:0] ch, input bit typed, input t_token typed_tok);
        t_token tok;
        int     i;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
            if (src_bursty) begin
                i_src_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_src_valid   <= 1'b1;
        i_source_byte <= ch;
        @(posedge i_clk);
        while (o_src_stall) @(posedge i_clk);

        scan_byte(ch);
        if (typed) begin
            tokens_due.push_back(typed_tok);
        end else begin
            for (i = 0; i < step_tokens.size(); i++) begin
                tok      = step_tokens[i];
                tok.last = (i == step_tokens.size() - 1);
                tokens_due.push_back(tok);
            end
        end
        n_sent++;
    endtask

    task automatic send_plain(input logic [7:0] ch);
        send_char(ch, 1'b0, '0);
    endtask

    // Hold the source side until every queued token has come out
    task automatic pause_until_drained();
        i_src_valid <= 1'b0;
        @(posedge i_clk);
        while (tokens_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] random_letter();
        logic [7:0] c;
        c = CH_LOW_A + 8'($urandom_range(0, 25));
        if ($urandom_range(0, 3) == 0) c = c & ~CASE_BIT;
        return c;
    endfunction

    function automatic logic [7:0] random_word_char();
        case ($urandom_range(0, 3))
            0, 1:    return random_letter();
            2:       return CH_ZERO + 8'($urandom_range(0, 9));
            default: return CH_UNDER;
        endcase
    endfunction

    // Build one piece of random source text into frag
    task automatic make_fragment();
        t_frag      pick;
        string      w;
        logic [7:0] c;
        int         j;
        frag.delete();
        pick = t_frag'($urandom_range(0, FRAG_END));
        case (pick)
            FRAG_KEYWORD: begin
                w = kw_text[$urandom_range(0, NUM_WORDS - 1)];
                for (j = 0; j < w.len(); j++) frag.push_back(w[j]);
                // near misses: capitalized or one character too long
                if ($urandom_range(0, 5) == 0) frag[0] = frag[0] & ~CASE_BIT;
                if ($urandom_range(0, 4) == 0) frag.push_back(random_word_char());
            end
            FRAG_IDENT: begin
                frag.push_back(($urandom_range(0, 4) == 0) ? CH_UNDER : random_letter());
                repeat ($urandom_range(0, 9)) frag.push_back(random_word_char());
            end
            FRAG_NUMBER: begin
                frag.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                repeat ($urandom_range(0, 4)) frag.push_back(random_word_char());
            end
            FRAG_OPERATOR: begin
                w = op_text[$urandom_range(0, NUM_OPS - 1)];
                for (j = 0; j < w.len(); j++) frag.push_back(w[j]);
            end
            FRAG_COMMENT: begin
                frag.push_back(CH_SLASH);
                frag.push_back(CH_SLASH);
                repeat ($urandom_range(0, 8)) begin
                    c = 8'($urandom_range(1, 255));
                    frag.push_back((c == CH_NL) ? CH_SEMI : c);
                end
                frag.push_back(($urandom_range(0, 5) == 0) ? CH_NUL : CH_NL);
            end
            FRAG_BLANK: begin
                frag.push_back(CH_TAB + 8'($urandom_range(0, 4)));
                if ($urandom_range(0, 1) == 0) frag[0] = CH_SPACE;
            end
            FRAG_NOISE: begin
                frag.push_back(8'($urandom_range(1, 255)));
            end
            default: begin
                frag.push_back(($urandom_range(0, 1) == 0) ? CH_NUL : CH_SPACE);
            end
        endcase
        // often join pieces directly so that one byte can close a word and start a token
        case ($urandom_range(0, 3))
            2:       frag.push_back(CH_SPACE);
            3:       frag.push_back(CH_NL);
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            n_errors++;
        end
    endtask

    // Check one accepted token transaction against the oldest expectation
    task automatic check_token();
        t_token want;
        if (tokens_due.size() == 0) begin
            $error("token: none expected, got kind %0d at %0d:%0d",
                   o_token_kind, o_start_line, o_start_column);
            n_errors++;
        end else begin
            want = tokens_due.pop_front();
            compare_field("token_kind", 16'(want.kind), 16'(o_token_kind));
            compare_field("word_index", 16'(want.word_index), 16'(o_word_index));
            compare_field("start_line", want.line, o_start_line);
            compare_field("start_column", want.column, o_start_column);
            compare_field("token_length", 16'(want.length), 16'(o_token_length));
            compare_field("last_of_run", 16'(want.last), 16'(o_last_of_run));
            n_checked++;
        end
    endtask

    // Token side: check accepted transactions, then pick the next stall value
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_tok_valid && !i_tok_stall) check_token();
            if (hold_served != hold_asked) begin
                hold_served = hold_asked;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_tok_stall <= 1'b1;
            end else begin
                if (stall_span == 0) begin
                    stall_style = t_stall_style'($urandom_range(0, STALL_TOGGLE));
                    stall_span  = $urandom_range(8, 48);
                end
                stall_span--;
                case (stall_style)
                    STALL_NONE:  i_tok_stall <= 1'b0;
                    STALL_LIGHT: i_tok_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_tok_stall <= 1'($urandom_range(0, 1));
                    default:     i_tok_stall <= ~i_tok_stall;
                endcase
            end
        end
    end

    // Main sequence
    initial begin
        int  i;
        int  n_random;
        int  spin;
        bit  hold_done;
        bit  pause_done;

        clear_scan();
        n_random   = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (i = 0; i < NUM_ROWS; i++)
            send_char(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].tok);
        pause_until_drained();

        // Random text, mostly well-formed tokens with some noise mixed in
        while (n_random < RANDOM_BYTES) begin
            if (!hold_done && n_random >= RANDOM_BYTES / 2) begin
                // starve the token side while bytes keep coming, two tokens each pair
                hold_done = 1'b1;
                hold_asked++;
                src_bursty = 1'b0;
                repeat (30) begin
                    send_plain("a");
                    send_plain(CH_RPAREN);
                end
                src_bursty = 1'b1;
            end
            if (!pause_done && n_random >= RANDOM_BYTES * 3 / 4) begin
                pause_done = 1'b1;
                pause_until_drained();
            end
            make_fragment();
            for (i = 0; i < frag.size(); i++) send_plain(frag[i]);
            n_random += frag.size();
        end

        // Saturate token length from home positions
        src_bursty = 1'b0;
        send_plain(CH_NUL);
        repeat (LONG_WORD) send_plain("a");
        send_plain(CH_SPACE);
        // end of text inside a comment
        send_plain(CH_SLASH);
        send_plain(CH_SLASH);
        send_plain(CH_NUL);

        // Drain and settle
        i_src_valid <= 1'b0;
        @(posedge i_clk);
        spin = 0;
        while (tokens_due.size() != 0 && spin < DRAIN_LIMIT) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (tokens_due.size() != 0) begin
            $error("token: %0d expected tokens never arrived", tokens_due.size());
            n_errors++;
        end

        $display("Sent %0d source bytes and checked %0d tokens, %0d mismatches.",
                 n_sent, n_checked, n_errors);
        $display("Covered words, operators, comments, stray bytes, stalls and long words.");
        if (n_errors == 0)
            $display("[source_tokenizer_top] OK");
        else
            $display("[source_tokenizer_top] ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_NS);
        $display("[source_tokenizer_top] ERROR");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/stok_pkg.sv
src/source_tokenizer_top.sv
sim/source_tokenizer_top_tb.sv
